// ===== design/room_booking_scheduler_assert.svh =====
// Assertion macros used by the room booking scheduler RTL.
`ifndef ROOM_BOOKING_SCHEDULER_ASSERT_SVH
`define ROOM_BOOKING_SCHEDULER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("room booking scheduler: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("room booking scheduler: next-cycle check failed");

`endif

// ===== design/rbs_pkg.sv =====
// Shared widths, types and constants of the room booking scheduler.
package rbs_pkg;

  localparam int TIME_W   = 32;
  localparam int FINISH_W = 48;
  localparam int COUNT_W  = 32;
  localparam int IDX_W    = 4;
  localparam int CFG_W    = 5;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [FINISH_W-1:0] finish_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CFG_W-1:0]    cfg_t;

  localparam cfg_t    ROOMS_RESET = 5'd16;
  localparam finish_t FINISH_MAX  = {FINISH_W{1'b1}};
  localparam count_t  COUNT_MAX   = {COUNT_W{1'b1}};

endpackage

// ===== design/room_booking_scheduler.sv =====
// An accepted request is held in the input register, then processed into the result
// register when the result side is not stalled; its result is taken from there.
// Throughput: one request per cycle unless stalled; the free-room search, earliest-finish
// tree and room state update are combinational between the input and result registers.
// A stalled result holds the input register, which then stalls the request side.
// Reset clears all finish times, counts, the best room and the last start; rooms_in_use is 16.
module room_booking_scheduler #(
  parameter int MAX_ROOMS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  rbs_pkg::cfg_t    cfg_wr_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rbs_pkg::time_t   start_time_i,
  input  rbs_pkg::time_t   end_time_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rbs_pkg::idx_t    room_index_o,
  output rbs_pkg::finish_t actual_end_o,
  output logic             was_delayed_o,
  output rbs_pkg::idx_t    best_room_o,
  output rbs_pkg::count_t  best_count_o,
  output logic             bad_item_o
);
  import rbs_pkg::*;

  `include "room_booking_scheduler_assert.svh"

  localparam int RoomW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  cfg_t                      rooms_q;
  logic                      in_valid_q;
  time_t                     start_q;
  time_t                     end_q;
  logic                      advance;
  logic                      process;
  logic                      bad;
  logic                      upd_en;
  finish_t [MAX_ROOMS-1:0]   finish;
  time_t                     prev_start;
  logic [RoomW-1:0]          sel_room;
  logic                      sel_delayed;
  finish_t                   old_finish;
  logic [FINISH_W:0]         delay_sum;
  finish_t                   new_finish;
  logic [RoomW-1:0]          top_room;
  count_t                    top_count;

  logic    out_valid_q;
  idx_t    room_index_q;
  finish_t actual_end_q;
  logic    was_delayed_q;
  idx_t    best_room_q;
  count_t  best_count_q;
  logic    bad_item_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign bad    = (start_q < prev_start) || (end_q <= start_q);
  assign upd_en = process && !bad;

  rbs_select #(
    .NumRooms(MAX_ROOMS),
    .RoomW   (RoomW)
  ) u_select (
    .finish_i      (finish),
    .start_i       (start_q),
    .rooms_in_use_i(rooms_q),
    .room_o        (sel_room),
    .delayed_o     (sel_delayed),
    .old_finish_o  (old_finish)
  );

  assign delay_sum  = {1'b0, old_finish} + (FINISH_W + 1)'(end_q - start_q);
  assign new_finish = !sel_delayed ? FINISH_W'(end_q) :
                      delay_sum[FINISH_W] ? FINISH_MAX : delay_sum[FINISH_W-1:0];

  rbs_rooms #(
    .NumRooms(MAX_ROOMS),
    .RoomW   (RoomW)
  ) u_rooms (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_en_i        (upd_en),
    .room_i          (sel_room),
    .new_finish_i    (new_finish),
    .start_i         (start_q),
    .finish_o        (finish),
    .prev_start_o    (prev_start),
    .next_top_room_o (top_room),
    .next_top_count_o(top_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q     <= ROOMS_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        rooms_q <= cfg_wr_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
    end
    if (process) begin
      room_index_q  <= bad ? '0 : IDX_W'(sel_room);
      actual_end_q  <= bad ? '0 : new_finish;
      was_delayed_q <= !bad && sel_delayed;
      best_room_q   <= IDX_W'(top_room);
      best_count_q  <= top_count;
      bad_item_q    <= bad;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign room_index_o  = room_index_q;
  assign actual_end_o  = actual_end_q;
  assign was_delayed_o = was_delayed_q;
  assign best_room_o   = best_room_q;
  assign best_count_o  = best_count_q;
  assign bad_item_o    = bad_item_q;

  `RBS_ASSERT_SAME(a_bad_result_clear, clk_i, rst_ni, out_valid_o && bad_item_o,
                   room_index_o == '0 && actual_end_o == '0 && !was_delayed_o)
  `RBS_ASSERT_NEXT(a_processed_gives_result, clk_i, rst_ni, process,
                   out_valid_o)
  `RBS_ASSERT_SAME(a_no_update_when_stalled, clk_i, rst_ni, in_stall_o,
                   !upd_en)

endmodule

// ===== design/rbs_select.sv =====
// Room selection: lowest free room, or earliest-finishing room via a compare tree.
module rbs_select #(
  parameter int NumRooms = 16,
  parameter int RoomW    = 4
) (
  input  rbs_pkg::finish_t [NumRooms-1:0] finish_i,
  input  rbs_pkg::time_t                  start_i,
  input  rbs_pkg::cfg_t                   rooms_in_use_i,
  output logic [RoomW-1:0]                room_o,
  output logic                            delayed_o,
  output rbs_pkg::finish_t                old_finish_o
);
  import rbs_pkg::*;

  localparam int P    = 1 << RoomW;
  localparam int KeyW = FINISH_W + 1;

  logic [NumRooms-1:0] enable;
  logic [NumRooms-1:0] free;
  logic [RoomW-1:0]    free_idx;
  logic [KeyW-1:0]     key [RoomW+1][P];
  logic [RoomW-1:0]    idx [RoomW+1][P];

  always_comb begin
    for (int i = 0; i < NumRooms; i++) begin
      enable[i] = (i == 0) || (i < int'(rooms_in_use_i));
      free[i]   = enable[i] && (finish_i[i] <= FINISH_W'(start_i));
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = NumRooms - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_idx = RoomW'(i);
      end
    end
  end

  always_comb begin
    for (int l = 0; l <= RoomW; l++) begin
      for (int n = 0; n < P; n++) begin
        key[l][n] = '0;
        idx[l][n] = '0;
      end
    end
    for (int n = 0; n < P; n++) begin
      idx[0][n] = RoomW'(n);
      if (n < NumRooms) begin
        key[0][n] = {~enable[n], finish_i[n]};
      end else begin
        key[0][n] = {KeyW{1'b1}};
      end
    end
    for (int l = 0; l < RoomW; l++) begin
      for (int n = 0; n < (P >> (l + 1)); n++) begin
        if (key[l][2*n] <= key[l][2*n+1]) begin
          key[l+1][n] = key[l][2*n];
          idx[l+1][n] = idx[l][2*n];
        end else begin
          key[l+1][n] = key[l][2*n+1];
          idx[l+1][n] = idx[l][2*n+1];
        end
      end
    end
  end

  assign delayed_o    = ~(|free);
  assign room_o       = delayed_o ? idx[RoomW][0] : free_idx;
  assign old_finish_o = key[RoomW][0][FINISH_W-1:0];

endmodule

// ===== design/rbs_rooms.sv =====
// Room state: finish times, booking counts, running best room and last start.
module rbs_rooms #(
  parameter int NumRooms = 16,
  parameter int RoomW    = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_en_i,
  input  logic [RoomW-1:0]                room_i,
  input  rbs_pkg::finish_t                new_finish_i,
  input  rbs_pkg::time_t                  start_i,
  output rbs_pkg::finish_t [NumRooms-1:0] finish_o,
  output rbs_pkg::time_t                  prev_start_o,
  output logic [RoomW-1:0]                next_top_room_o,
  output rbs_pkg::count_t                 next_top_count_o
);
  import rbs_pkg::*;

  finish_t          finish_q   [NumRooms];
  count_t           bookings_q [NumRooms];
  logic [RoomW-1:0] top_room_q;
  logic [RoomW-1:0] top_room_d;
  count_t           top_count_q;
  count_t           top_count_d;
  time_t            prev_start_q;
  count_t           cur_count;
  count_t           inc_count;
  logic             better;

  always_comb begin
    for (int i = 0; i < NumRooms; i++) begin
      finish_o[i] = finish_q[i];
    end
  end

  assign cur_count = bookings_q[room_i];
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
  assign better    = (inc_count > top_count_q) ||
                     ((inc_count == top_count_q) && (room_i < top_room_q));

  always_comb begin
    top_room_d  = top_room_q;
    top_count_d = top_count_q;
    if (upd_en_i && better) begin
      top_room_d  = room_i;
      top_count_d = inc_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRooms; i++) begin
        finish_q[i]   <= '0;
        bookings_q[i] <= '0;
      end
      top_room_q   <= '0;
      top_count_q  <= '0;
      prev_start_q <= '0;
    end else begin
      top_room_q  <= top_room_d;
      top_count_q <= top_count_d;
      if (upd_en_i) begin
        finish_q[room_i]   <= new_finish_i;
        bookings_q[room_i] <= inc_count;
        prev_start_q       <= start_i;
      end
    end
  end

  assign prev_start_o     = prev_start_q;
  assign next_top_room_o  = top_room_d;
  assign next_top_count_o = top_count_d;

endmodule
